// ===== hw/rtl/slfa_pkg.sv =====
package slfa_pkg;

   // frame store geometry
   localparam int BufDepth = 256;
   localparam int IdxW     = $clog2(BufDepth);
   localparam int CntW     = IdxW + 1;

   // special characters
   localparam logic [7:0] ChLf  = 8'h0A;
   localparam logic [7:0] ChCr  = 8'h0D;
   localparam logic [7:0] ChNul = 8'h00;

   // operation codes of an input item
   typedef enum logic [1:0] {
      OpRecv    = 2'd0,
      OpRelease = 2'd1,
      OpRead    = 2'd2
   } op_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CsrFrameMode = 1'b0,
      CsrMinHeader = 1'b1
   } csr_idx_type;

   // frame end modes
   localparam logic ModeLine   = 1'b0;
   localparam logic ModeHeader = 1'b1;

   // command handed from the front part to the back part
   typedef struct packed {
      logic            write_en;
      logic            read_en;
      logic            term;
      logic [IdxW-1:0] addr;
      logic [7:0]      data;
      logic            frame_done;
      logic [7:0]      frame_length;
      logic            frame_held;
      logic            byte_dropped;
      logic            overflow;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic       frame_done;
      logic [7:0] frame_length;
      logic [7:0] read_data;
      logic       frame_held;
      logic       byte_dropped;
      logic       overflow;
   } rsp_type;

endpackage

// ===== hw/rtl/slfa_channels.sv =====
interface slfa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, output operation, output rx_byte, output read_index,
                   input ready);
   modport sink   (input valid, input operation, input rx_byte, input read_index,
                   output ready);
endinterface

interface slfa_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic [7:0] frame_length;
   logic [7:0] read_data;
   logic       frame_held;
   logic       byte_dropped;
   logic       overflow;

   modport source (output valid, output frame_done, output frame_length, output read_data,
                   output frame_held, output byte_dropped, output overflow, input ready);
   modport sink   (input valid, input frame_done, input frame_length, input read_data,
                   input frame_held, input byte_dropped, input overflow, output ready);
endinterface

// ===== hw/rtl/serial_line_frame_assembler.sv =====
// Serial line frame assembler.
// req_ch carries one operation per transfer: receive a byte, release the
// held frame, or read a frame store entry. rsp_ch returns exactly one result
// per request, in order: frame end flag and length, read data, held flag,
// dropped flag and overflow flag.
// csr_write_enable/csr_index/csr_write_data set frame_mode (index 0) and
// min_header_length (index 1); write them only while the block is idle.
// Results are registered after the queue; throughput is one item per cycle
// while results are taken, set by the combinational front classifier and
// the single write port of the frame store (the zero after a frame is
// written in the following cycle, when no byte can be stored).
// A 2-entry command queue sits between front and back: when the receiver
// stalls, the output register holds its result, the queue fills and
// req_ch.ready drops once two commands wait.
// Synchronous reset clears fill count, held flag, byte history, queue and
// output valid; frame_mode returns to 0 and min_header_length to 16. The
// frame store is not cleared and needs no clearing pass.
module serial_line_frame_assembler (
   input  logic       clock,
   input  logic       reset,
   slfa_req_if.sink   req_ch,
   slfa_rsp_if.source rsp_ch,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_write_data
);

   logic              accept;
   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   slfa_pkg::cmd_type front_cmd;
   slfa_pkg::cmd_type back_cmd;
   slfa_pkg::rsp_type rsp;

   // request transfer
   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   slfa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .operation        (req_ch.operation),
      .rx_byte          (req_ch.rx_byte),
      .read_index       (req_ch.read_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (front_cmd)
   );

   slfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (back_cmd)
   );

   slfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (back_cmd),
      .pop       (q_pop),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp       (rsp)
   );

   // result fields
   assign rsp_ch.frame_done   = rsp.frame_done;
   assign rsp_ch.frame_length = rsp.frame_length;
   assign rsp_ch.read_data    = rsp.read_data;
   assign rsp_ch.frame_held   = rsp.frame_held;
   assign rsp_ch.byte_dropped = rsp.byte_dropped;
   assign rsp_ch.overflow     = rsp.overflow;

endmodule

// ===== hw/rtl/slfa_front.sv =====
module slfa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            operation,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            read_index,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [7:0]            csr_write_data,
   output slfa_pkg::cmd_type     cmd
);

   logic                       frame_mode_ff, frame_mode_in;
   logic [7:0]                 min_header_ff, min_header_in;
   logic [slfa_pkg::IdxW-1:0]  fill_ff, fill_in;
   logic                       held_ff, held_in;
   logic [23:0]                recent_ff, recent_in;

   logic [slfa_pkg::CntW-1:0]  new_cnt;
   logic                       full;
   logic                       term;
   logic                       in_range;

   // configuration writes
   always_comb begin
      frame_mode_in = frame_mode_ff;
      min_header_in = min_header_ff;
      if (csr_write_enable) begin
         unique case (slfa_pkg::csr_idx_type'(csr_index))
            slfa_pkg::CsrFrameMode: frame_mode_in = csr_write_data[0];
            slfa_pkg::CsrMinHeader: min_header_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // frame end detection for a received byte
   always_comb begin
      new_cnt  = slfa_pkg::CntW'(fill_ff) + slfa_pkg::CntW'(1);
      full     = (fill_ff == slfa_pkg::IdxW'(slfa_pkg::BufDepth - 2));
      in_range = (32'(read_index) < slfa_pkg::BufDepth);
      if (frame_mode_ff == slfa_pkg::ModeLine) begin
         term = (rx_byte == slfa_pkg::ChCr) || (rx_byte == slfa_pkg::ChLf);
      end else begin
         term = (32'(new_cnt) > 32'(min_header_ff)) &&
                ({recent_ff, rx_byte} ==
                 {slfa_pkg::ChCr, slfa_pkg::ChLf, slfa_pkg::ChCr, slfa_pkg::ChLf});
      end
   end

   // classify the item and work out its result fields
   always_comb begin
      fill_in   = fill_ff;
      held_in   = held_ff;
      recent_in = recent_ff;
      cmd       = '0;
      cmd.data  = rx_byte;
      cmd.addr  = fill_ff;
      case (slfa_pkg::op_type'(operation))
         slfa_pkg::OpRecv: begin
            if (held_ff) begin
               cmd.byte_dropped = 1'b1;
            end else begin
               cmd.write_en = 1'b1;
               if (term || full) begin
                  cmd.term         = 1'b1;
                  cmd.frame_done   = 1'b1;
                  cmd.frame_length = 8'(new_cnt);
                  cmd.overflow     = !term;
                  held_in          = 1'b1;
                  fill_in          = '0;
                  recent_in        = '0;
               end else begin
                  fill_in   = slfa_pkg::IdxW'(new_cnt);
                  recent_in = {recent_ff[15:0], rx_byte};
               end
            end
         end
         slfa_pkg::OpRelease: begin
            held_in = 1'b0;
         end
         slfa_pkg::OpRead: begin
            cmd.read_en = in_range;
            cmd.addr    = slfa_pkg::IdxW'(read_index);
         end
         default: ;
      endcase
      cmd.frame_held = held_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_mode_ff <= slfa_pkg::ModeLine;
         min_header_ff <= 8'd16;
         fill_ff       <= '0;
         held_ff       <= 1'b0;
         recent_ff     <= '0;
      end else begin
         frame_mode_ff <= frame_mode_in;
         min_header_ff <= min_header_in;
         if (accept) begin
            fill_ff   <= fill_in;
            held_ff   <= held_in;
            recent_ff <= recent_in;
         end
      end
   end

endmodule

// ===== hw/rtl/slfa_queue.sv =====
module slfa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  slfa_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output slfa_pkg::cmd_type pop_cmd
);

   slfa_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   // status and head of queue
   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      pop_cmd   = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/slfa_back.sv =====
module slfa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  slfa_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slfa_pkg::rsp_type rsp
);

   logic [7:0]                frame_store [slfa_pkg::BufDepth];

   logic                      out_valid_ff, out_valid_in;
   slfa_pkg::cmd_type         out_cmd_ff;
   logic [7:0]                rd_data_ff;
   logic                      rd_zero_ff;
   logic                      nul_pend_ff, nul_pend_in;
   logic [slfa_pkg::IdxW-1:0] nul_addr_ff;

   logic                      mem_we;
   logic [slfa_pkg::IdxW-1:0] mem_wa;
   logic [7:0]                mem_wd;
   logic                      mem_re;

   // take the next command when the output register is free or drains
   always_comb begin
      pop          = cmd_valid && (!out_valid_ff || rsp_ready);
      out_valid_in = pop || (out_valid_ff && !rsp_ready);
      nul_pend_in  = pop && cmd.write_en && cmd.term;
      mem_re       = pop && cmd.read_en;
      // the terminating zero goes in the cycle after the last byte
      mem_we       = nul_pend_ff || (pop && cmd.write_en);
      mem_wa       = nul_pend_ff ? nul_addr_ff : cmd.addr;
      mem_wd       = nul_pend_ff ? slfa_pkg::ChNul : cmd.data;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         nul_pend_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         nul_pend_ff  <= nul_pend_in;
      end
   end

   // output register and pending zero address
   always_ff @(posedge clock) begin
      if (pop) begin
         out_cmd_ff <= cmd;
      end
      if (nul_pend_in) begin
         nul_addr_ff <= cmd.addr + slfa_pkg::IdxW'(1);
      end
      if (mem_re) begin
         rd_zero_ff <= nul_pend_ff && (cmd.addr == nul_addr_ff);
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= frame_store[cmd.addr];
      end
   end

   // result item
   always_comb begin
      rsp_valid        = out_valid_ff;
      rsp.frame_done   = out_cmd_ff.frame_done;
      rsp.frame_length = out_cmd_ff.frame_length;
      rsp.read_data    = (out_cmd_ff.read_en && !rd_zero_ff) ? rd_data_ff : 8'd0;
      rsp.frame_held   = out_cmd_ff.frame_held;
      rsp.byte_dropped = out_cmd_ff.byte_dropped;
      rsp.overflow     = out_cmd_ff.overflow;
   end

endmodule
